### rtl/core/kdct_pkg.sv
// kdct_pkg: shared types, constants and the byte-wide CRC-16 step for the
// keyed double CRC-16 tag block. No dependencies.
package kdct_pkg;

  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;
  localparam logic [63:0] SECRET_KEY_RESET = 64'hAABB_CCDD_EEFF_0001;
  localparam int unsigned SECRET_BYTES_DEF = 8;
  localparam int unsigned KEY_BYTES_MAX    = 8;
  localparam int unsigned KEY_IDX_W        = $clog2(KEY_BYTES_MAX);

  localparam logic OP_CHALLENGE = 1'b0;
  localparam logic OP_MAC       = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] tag;
    logic        tag_kind;
  } out_item_t;

  // Byte source for the CRC step
  typedef enum logic [2:0] {
    SRC_IN,
    SRC_ITEM,
    SRC_RESP_HI,
    SRC_RESP_LO,
    SRC_KEY,
    SRC_TAG_HI,
    SRC_TAG_LO
  } kdct_src_e;

  // Controller -> datapath commands
  typedef struct packed {
    kdct_src_e              src;
    logic                   step;      // run one CRC byte step
    logic                   start;     // seed the step from CRC_INIT
    logic                   capture;   // latch the input beat
    logic                   hold;      // save pre-tag CRC for the low byte
    logic                   clear;     // crc back to CRC_INIT
    logic                   load_out;  // load the result register
    logic                   store_resp;
    logic                   kind;
    logic [KEY_IDX_W-1:0]   key_idx;
  } kdct_cmd_t;

  // One reflected CRC-16 step over a byte, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/kdct_ctrl.sv
// kdct_ctrl: sequencer for the keyed double CRC-16 tag block.
// Depends on kdct_pkg; drives kdct_datapath through kdct_cmd_t.
module kdct_ctrl import kdct_pkg::*; #(
  parameter int unsigned SECRET_BYTES = SECRET_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_op_i,
  input  logic      in_last_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output kdct_cmd_t cmd_o
);

  localparam logic [KEY_IDX_W-1:0] KEY_LAST = KEY_IDX_W'(SECRET_BYTES - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP_HI,
    ST_RESP_LO,
    ST_KEY_PRE,
    ST_DATA,
    ST_KEY_POST,
    ST_TAG_HI,
    ST_TAG_LO,
    ST_EMIT
  } state_e;

  state_e               state_q, state_d;
  logic [KEY_IDX_W-1:0] cnt_q, cnt_d;
  logic                 op_q, op_d;
  logic                 last_q, last_d;
  logic                 in_msg_q, in_msg_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    last_d      = last_q;
    in_msg_d    = in_msg_q;
    out_valid_d = out_valid_q && out_stall_i;

    cmd_o            = '0;
    cmd_o.src        = SRC_IN;
    cmd_o.kind       = op_q;
    cmd_o.key_idx    = cnt_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d          = in_op_i;
          last_d        = in_last_i;
          cmd_o.capture = 1'b1;
          if (!in_msg_q && (in_op_i == OP_MAC)) begin
            state_d = ST_RESP_HI;
          end else begin
            cmd_o.step  = 1'b1;
            cmd_o.start = !in_msg_q;
            in_msg_d    = 1'b1;
            if (in_last_i) begin
              cnt_d   = '0;
              state_d = (in_op_i == OP_CHALLENGE) ? ST_KEY_POST : ST_TAG_HI;
            end
          end
        end
      end
      ST_RESP_HI: begin
        cmd_o.step  = 1'b1;
        cmd_o.start = 1'b1;
        cmd_o.src   = SRC_RESP_HI;
        state_d     = ST_RESP_LO;
      end
      ST_RESP_LO: begin
        cmd_o.step = 1'b1;
        cmd_o.src  = SRC_RESP_LO;
        cnt_d      = '0;
        state_d    = ST_KEY_PRE;
      end
      ST_KEY_PRE: begin
        cmd_o.step = 1'b1;
        cmd_o.src  = SRC_KEY;
        if (cnt_q == KEY_LAST) begin
          state_d = ST_DATA;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DATA: begin
        cmd_o.step = 1'b1;
        cmd_o.src  = SRC_ITEM;
        in_msg_d   = 1'b1;
        if (last_q) begin
          cnt_d   = '0;
          state_d = (op_q == OP_CHALLENGE) ? ST_KEY_POST : ST_TAG_HI;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_KEY_POST: begin
        cmd_o.step = 1'b1;
        cmd_o.src  = SRC_KEY;
        if (cnt_q == KEY_LAST) begin
          state_d = ST_TAG_HI;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_TAG_HI: begin
        cmd_o.step  = 1'b1;
        cmd_o.start = 1'b1;
        cmd_o.hold  = 1'b1;
        cmd_o.src   = SRC_TAG_HI;
        state_d     = ST_TAG_LO;
      end
      ST_TAG_LO: begin
        cmd_o.step = 1'b1;
        cmd_o.src  = SRC_TAG_LO;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.store_resp = (op_q == OP_CHALLENGE);
          cmd_o.clear      = 1'b1;
          in_msg_d         = 1'b0;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      op_q        <= 1'b0;
      last_q      <= 1'b0;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      op_q        <= op_d;
      last_q      <= last_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/core/kdct_datapath.sv
// kdct_datapath: CRC register, byte mux, stored response, key and result
// registers. Depends on kdct_pkg; controlled by kdct_ctrl.
module kdct_datapath import kdct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  kdct_cmd_t cmd_i,
  input  in_item_t  in_item_i,
  input  logic      cfg_we_i,
  input  logic [63:0] cfg_data_i,
  output out_item_t out_item_o
);

  logic [15:0] crc_q, crc_d;
  logic [15:0] resp_q;
  logic [15:0] hold_q;
  logic [63:0] key_q;
  logic [7:0]  item_byte_q;
  out_item_t   out_q;
  logic [15:0] seed;
  logic [7:0]  step_byte;
  logic [7:0]  key_byte;

  assign key_byte = key_q[8*(KEY_BYTES_MAX - 1 - int'(cmd_i.key_idx)) +: 8];
  assign seed     = cmd_i.start ? CRC_INIT : crc_q;

  always_comb begin
    case (cmd_i.src)
      SRC_IN:      step_byte = in_item_i.data_byte;
      SRC_ITEM:    step_byte = item_byte_q;
      SRC_RESP_HI: step_byte = resp_q[15:8];
      SRC_RESP_LO: step_byte = resp_q[7:0];
      SRC_KEY:     step_byte = key_byte;
      SRC_TAG_HI:  step_byte = crc_q[15:8];
      SRC_TAG_LO:  step_byte = hold_q[7:0];
      default:     step_byte = in_item_i.data_byte;
    endcase
  end

  always_comb begin
    if (cmd_i.clear) begin
      crc_d = CRC_INIT;
    end else if (cmd_i.step) begin
      crc_d = crc16_byte(seed, step_byte);
    end else begin
      crc_d = crc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_INIT;
      resp_q <= '0;
      key_q  <= SECRET_KEY_RESET;
    end else begin
      crc_q <= crc_d;
      if (cmd_i.store_resp) begin
        resp_q <= crc_q;
      end
      if (cfg_we_i) begin
        key_q <= cfg_data_i;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_byte_q <= in_item_i.data_byte;
    end
    if (cmd_i.hold) begin
      hold_q <= crc_q;
    end
    if (cmd_i.load_out) begin
      out_q.tag      <= crc_q;
      out_q.tag_kind <= cmd_i.kind;
    end
  end

  assign out_item_o = out_q;

endmodule

### rtl/core/keyed_double_crc16_tag.sv
// keyed_double_crc16_tag: top level of the keyed double CRC-16 tag block.
// Depends on kdct_pkg, kdct_ctrl and kdct_datapath.
//
// A non-final byte is stepped as it is accepted, except a byte that opens a MAC,
// which goes through accept, stored response and key prefix, then the byte. A final
// byte adds the key tail for a challenge, then the tag high and low steps and the result
// register load, held off under a stalled result; the result beat shows the cycle after.
// Throughput is set by the single byte-wide CRC unit: one byte per cycle while in_stall_o is low.
// Reset (async, active low): idle, no message open, CRC 0xFFFF, stored
// response 0, secret key 0xAABBCCDDEEFF0001, no result pending.
module keyed_double_crc16_tag import kdct_pkg::*; #(
  parameter int unsigned SECRET_BYTES = SECRET_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats: one message or nonce byte each
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  // result beats: one tag per finished nonce or message
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  // secret key write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i
);

  kdct_cmd_t cmd;

  // The user must issue key writes only while idle; the block does not enforce it, and the port never back-pressures.
  assign cfg_ready_o = 1'b1;

  // Controller: walks prefix, data, key tail and tag re-CRC one byte a cycle.
  kdct_ctrl #(
    .SECRET_BYTES (SECRET_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_item_i.operation),
    .in_last_i   (in_item_i.last_byte),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Datapath: CRC register with a byte mux feeding one unrolled CRC step.
  kdct_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_item_o (out_item_o)
  );

endmodule

### rtl/core/kdct_checker.sv
// kdct_checker: port-level assertions for keyed_double_crc16_tag, bound in.
// Depends on kdct_pkg.
module kdct_checker import kdct_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input in_item_t    in_item_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_item_t   out_item_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result beat dropped or changed under stall");

  // a final byte always leaves the block busy with the tail
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.last_byte |=> in_stall_o)
    else $error("no tail processing after final byte");

  // a new result only appears out of the busy emit phase
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised while input side idle");

  // a new result is always raised with the input side open again
  a_rise_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("block still busy after emitting a result");

endmodule

bind keyed_double_crc16_tag kdct_checker u_kdct_checker (.*);
